@@ hw/rtl/updown_decimal_timer_fsm_unit_assert.svh @@
// assertion macros for the up/down decimal timer
`ifndef UPDOWN_DECIMAL_TIMER_FSM_UNIT_ASSERT_SVH
`define UPDOWN_DECIMAL_TIMER_FSM_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define UDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/udt_pkg.sv @@
// shared types, codes and helper functions of the up/down decimal timer
`default_nettype none

package udt_pkg;

  localparam int unsigned DIGITS = 4;
  localparam logic [3:0] DIGIT_MAX   = 4'd9;
  localparam logic [3:0] DIGIT_BLANK = 4'd15;

  // key codes that act on the block
  localparam logic [3:0] KEY_RUN_PAUSE = 4'd1;
  localparam logic [3:0] KEY_CLEAR     = 4'd2;
  localparam logic [3:0] KEY_DIR       = 4'd3;

  // led patterns
  localparam logic [7:0] LED_RESET = 8'h7F;
  localparam logic [7:0] LED_RUN   = 8'h80;
  localparam logic [7:0] LED_PAUSE = 8'h00;

  localparam logic [7:0] TICKS_RESET = 8'd5;

  // mode codes as seen on the result item
  localparam logic [1:0] MODE_CODE_RUN    = 2'd0;
  localparam logic [1:0] MODE_CODE_PAUSE  = 2'd1;
  localparam logic [1:0] MODE_CODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_CODE_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    MODE_RUN   = 3'b001,
    MODE_PAUSE = 3'b010,
    MODE_CLEAR = 3'b100
  } mode_t;

  // four bcd digits, index 0 is ones, index 3 is thousands
  typedef logic [DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    mode_t      mode;
    logic       return_mode;
    logic       down_flag;
    bcd_t       count_bcd;
    logic [3:0] last_key;
    logic [7:0] prescale_count;
    bcd_t       shown;
    logic [7:0] led_bits;
  } state_t;

  // one step of the bcd count, wrapping at 0000 and 9999
  function automatic bcd_t bcd_step(input bcd_t value, input logic down);
    bcd_t res;
    logic carry;
    res = value;
    carry = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      if (carry) begin
        if (down) begin
          if (value[i] == 4'd0) begin
            res[i] = DIGIT_MAX;
          end else begin
            res[i] = value[i] - 4'd1;
            carry = 1'b0;
          end
        end else begin
          if (value[i] >= DIGIT_MAX) begin
            res[i] = 4'd0;
          end else begin
            res[i] = value[i] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
    return res;
  endfunction

  // all digits set to one value
  function automatic bcd_t bcd_fill(input logic [3:0] d);
    bcd_t res;
    for (int i = 0; i < DIGITS; i++) begin
      res[i] = d;
    end
    return res;
  endfunction

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] code;
    case (m)
      MODE_RUN:   code = MODE_CODE_RUN;
      MODE_PAUSE: code = MODE_CODE_PAUSE;
      MODE_CLEAR: code = MODE_CODE_CLEAR;
      default:    code = MODE_CODE_UNUSED;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/udt_step.sv @@
// next-state logic for one item: prescaler, key edges, mode machine, bcd count
`default_nettype none

module udt_step (
  input  udt_pkg::state_t cur,
  input  logic [3:0]      key_sample,
  input  logic            base_tick,
  input  logic [7:0]      ticks_per_step,
  output udt_pkg::state_t nxt
);
  import udt_pkg::*;

  logic [7:0] limit;
  logic [7:0] pre_inc;
  logic       step;
  logic       edge_run;
  logic       edge_clear;
  logic       edge_dir;
  bcd_t       stepped;

  always_comb begin
    nxt = cur;

    // prescaler, a zero register acts as one
    limit   = (ticks_per_step == 8'd0) ? 8'd1 : ticks_per_step;
    pre_inc = cur.prescale_count + 8'd1;
    step    = 1'b0;
    if (base_tick) begin
      nxt.prescale_count = pre_inc;
      if (pre_inc >= limit) begin
        nxt.prescale_count = 8'd0;
        step = 1'b1;
      end
    end

    // key edges against the previous sample
    nxt.last_key = key_sample;
    edge_run   = (cur.last_key != KEY_RUN_PAUSE) && (key_sample == KEY_RUN_PAUSE);
    edge_clear = (cur.last_key != KEY_CLEAR) && (key_sample == KEY_CLEAR);
    edge_dir   = (cur.last_key != KEY_DIR) && (key_sample == KEY_DIR);

    if (edge_dir) begin
      nxt.down_flag = !cur.down_flag;
    end

    // mode machine on the mode held at the start of the item
    case (cur.mode)
      MODE_RUN: begin
        if (edge_run) begin
          nxt.return_mode = 1'b0;
          nxt.mode = MODE_PAUSE;
        end
        if (edge_clear) begin
          nxt.count_bcd = nxt.down_flag ? bcd_fill(4'd0) : bcd_fill(DIGIT_MAX);
          nxt.return_mode = 1'b0;
          nxt.mode = MODE_CLEAR;
        end
        nxt.led_bits = LED_RUN;
      end
      MODE_PAUSE: begin
        if (edge_run) begin
          nxt.return_mode = 1'b1;
          nxt.mode = MODE_RUN;
        end
        if (edge_clear) begin
          nxt.count_bcd = nxt.down_flag ? bcd_fill(4'd0) : bcd_fill(DIGIT_MAX);
          nxt.return_mode = 1'b1;
          nxt.mode = MODE_CLEAR;
        end
        nxt.led_bits = LED_PAUSE;
      end
      MODE_CLEAR: begin
        nxt.shown = nxt.down_flag ? bcd_fill(DIGIT_MAX) : bcd_fill(4'd0);
        nxt.mode = cur.return_mode ? MODE_PAUSE : MODE_RUN;
      end
      default: begin
      end
    endcase

    // count step, dropped unless running
    stepped = bcd_step(nxt.count_bcd, nxt.down_flag);
    if (step && (nxt.mode == MODE_RUN)) begin
      nxt.count_bcd = stepped;
      nxt.shown = stepped;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/updown_decimal_timer_fsm_unit.sv @@
// Up/down four-digit decimal timer with run, pause and clear modes.
// Input channel s_*: one item per key sample, tdata = {base_tick, key_sample}.
// Output channel m_*: one result item per input item with the shown digits,
//   direction, led pattern and mode after that item.
// Config port: APB, one register ticks_per_step at byte address 0, reset 5.
// A result passes the input register, then the result register, after its
//   item is accepted. Throughput: one item per cycle while m_tready allows it; the
//   whole update is one pass of logic between the two registers.
// s_tready is high while the input register is empty or moves on, so an
//   item is taken while a finished result waits, as long as the result
//   register can be freed in the same cycle.
// When m_tready is low with a result held, the input register fills and
//   then s_tready drops; nothing is lost or repeated.
// Reset (rst, synchronous): mode running, counting down, count 0, digits
//   blank, leds 0x7F, prescaler 0, both stages empty.
`default_nettype none
`include "updown_decimal_timer_fsm_unit_assert.svh"

module updown_decimal_timer_fsm_unit (
  input  logic        clk,
  input  logic        rst,
  // input item
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] key_sample, [4] base_tick, [7:5] zero
  // result item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] digit_thousands, [7:4] digit_hundreds,
                                 // [11:8] digit_tens, [15:12] digit_ones,
                                 // [16] counting_down, [24:17] led_pattern,
                                 // [26:25] mode_now, [31:27] zero
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import udt_pkg::*;

  logic [7:0] ticks_per_step;
  logic       in_valid;
  logic [3:0] in_key;
  logic       in_tick;
  logic       advance;
  state_t     state;
  state_t     state_next;

  // config register
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, ticks_per_step};

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_step <= TICKS_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      ticks_per_step <= pwdata[7:0];
    end
  end

  // handshake between the two stages
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_key  <= s_tdata[3:0];
      in_tick <= s_tdata[4];
    end
  end

  udt_step u_step (
    .cur            (state),
    .key_sample     (in_key),
    .base_tick      (in_tick),
    .ticks_per_step (ticks_per_step),
    .nxt            (state_next)
  );

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode           <= MODE_RUN;
      state.return_mode    <= 1'b0;
      state.down_flag      <= 1'b1;
      state.count_bcd      <= bcd_fill(4'd0);
      state.last_key       <= 4'd0;
      state.prescale_count <= 8'd0;
      state.shown          <= bcd_fill(DIGIT_BLANK);
      state.led_bits       <= LED_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'd0, mode_code(state_next.mode), state_next.led_bits,
                  state_next.down_flag, state_next.shown[0], state_next.shown[1],
                  state_next.shown[2], state_next.shown[3]};
    end
  end

  // checks
  `UDT_ASSERT_NEXT(a_clear_one_item, advance && (state.mode == MODE_CLEAR), state.mode != MODE_CLEAR, "clear mode held past one item")
  `UDT_ASSERT_NOW(a_count_bcd, 1'b1, (state.count_bcd[0] <= DIGIT_MAX) && (state.count_bcd[1] <= DIGIT_MAX) && (state.count_bcd[2] <= DIGIT_MAX) && (state.count_bcd[3] <= DIGIT_MAX), "count digit out of range")
  `UDT_ASSERT_NEXT(a_in_held, in_valid && !advance, in_valid && $stable(in_key) && $stable(in_tick), "waiting item lost")
  `UDT_ASSERT_NEXT(a_state_only_on_advance, !advance, $stable(state), "state changed without an item")

endmodule

`default_nettype wire

@@ test/updown_decimal_timer_fsm_unit_test.sv @@
// testbench of the up/down decimal timer: directed and random key/tick items vs a predictor
`timescale 1ns / 1ps

module updown_decimal_timer_fsm_unit_test;
  import udt_pkg::*;

  localparam int COUNT_MODULUS = 10000;
  localparam int COUNT_TOP = COUNT_MODULUS - 1;
  localparam logic [2:0] REG_TICKS_ADDR = 3'd0;
  localparam logic [2:0] REG_BEYOND_ADDR = 3'd4;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 75;

  // result item as packed on m_tdata, lowest field last
  typedef struct packed {
    logic [4:0] pad;
    logic [1:0] mode;
    logic [7:0] leds;
    logic       down;
    logic [3:0] ones;
    logic [3:0] tens;
    logic [3:0] hundreds;
    logic [3:0] thousands;
  } display_t;

  // one row of the directed table: a register write or an input item
  typedef struct {
    bit          is_cfg;
    logic [2:0]  addr;
    logic [31:0] value;
    logic [3:0]  key;
    logic        tick;
    bit          typed;
    display_t    want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [3:0] key_sample, [4] base_tick, [7:5] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [3:0] thousands, [7:4] hundreds, [11:8] tens, [15:12] ones,
                          // [16] counting_down, [24:17] led_pattern, [26:25] mode_now
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [7:0] sw_ticks;
  logic [1:0] sw_mode;
  logic       sw_ret;
  logic       sw_down;
  int         sw_count;
  logic [3:0] sw_last_key;
  logic [7:0] sw_prescale;
  logic [3:0] sw_shown[4];
  logic [7:0] sw_leds;

  display_t display_due[$];
  row_t     dir_rows[$];
  bit       calm;
  int       mismatches;
  int       items_sent;
  int       results_seen;
  int       cfg_writes;

  updown_decimal_timer_fsm_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  // idle length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic display_t mk_display(input logic [3:0] th, input logic [3:0] hu,
                                          input logic [3:0] te, input logic [3:0] on,
                                          input logic dn, input logic [7:0] leds,
                                          input logic [1:0] mode);
    display_t d;
    d = '0;
    d.thousands = th;
    d.hundreds = hu;
    d.tens = te;
    d.ones = on;
    d.down = dn;
    d.leds = leds;
    d.mode = mode;
    return d;
  endfunction

  function automatic void stopwatch_reset();
    sw_ticks = TICKS_RESET;
    sw_mode = MODE_CODE_RUN;
    sw_ret = 1'b0;
    sw_down = 1'b1;
    sw_count = 0;
    sw_last_key = 4'd0;
    sw_prescale = 8'd0;
    for (int i = 0; i < 4; i++) sw_shown[i] = DIGIT_BLANK;
    sw_leds = LED_RESET;
  endfunction

  // advance the stopwatch by one key/tick item and return what it shows
  function automatic display_t stopwatch_advance(input logic [3:0] key, input logic tick);
    display_t   d;
    logic [7:0] lim;
    logic       step;
    logic [3:0] prev;
    logic       e_run;
    logic       e_clr;
    logic       e_dir;
    logic [1:0] start;
    lim = (sw_ticks == 8'd0) ? 8'd1 : sw_ticks;
    step = 1'b0;
    // prescaler
    if (tick) begin
      sw_prescale = sw_prescale + 8'd1;
      if (sw_prescale >= lim) begin
        sw_prescale = 8'd0;
        step = 1'b1;
      end
    end
    // key edges against the previous sample
    prev = sw_last_key;
    sw_last_key = key;
    e_run = (prev != KEY_RUN_PAUSE) && (key == KEY_RUN_PAUSE);
    e_clr = (prev != KEY_CLEAR) && (key == KEY_CLEAR);
    e_dir = (prev != KEY_DIR) && (key == KEY_DIR);
    if (e_dir) sw_down = ~sw_down;
    // mode machine on the mode held at the start of the item
    start = sw_mode;
    if (start == MODE_CODE_RUN || start == MODE_CODE_PAUSE) begin
      if (e_run) begin
        sw_ret = (start == MODE_CODE_PAUSE);
        sw_mode = (start == MODE_CODE_RUN) ? MODE_CODE_PAUSE : MODE_CODE_RUN;
      end
      if (e_clr) begin
        sw_count = sw_down ? 0 : COUNT_TOP;
        sw_ret = sw_mode[0];
        sw_mode = MODE_CODE_CLEAR;
      end
      sw_leds = (start == MODE_CODE_RUN) ? LED_RUN : LED_PAUSE;
    end else if (start == MODE_CODE_CLEAR) begin
      for (int i = 0; i < 4; i++) sw_shown[i] = sw_down ? DIGIT_MAX : 4'd0;
      sw_mode = {1'b0, sw_ret};
    end
    // count step, dropped unless running
    if (step && sw_mode == MODE_CODE_RUN) begin
      if (sw_down) sw_count = (sw_count == 0) ? COUNT_TOP : sw_count - 1;
      else sw_count = (sw_count + 1 >= COUNT_MODULUS) ? 0 : sw_count + 1;
      sw_shown[0] = 4'((sw_count / 1000) & 15);
      sw_shown[1] = 4'((sw_count / 100) % 10);
      sw_shown[2] = 4'((sw_count / 10) % 10);
      sw_shown[3] = 4'(sw_count % 10);
    end
    d = mk_display(sw_shown[0], sw_shown[1], sw_shown[2], sw_shown[3], sw_down, sw_leds,
                   sw_mode);
    return d;
  endfunction

  function automatic void add_item(input logic [3:0] key, input logic tick);
    row_t r;
    r = '{default: '0};
    r.key = key;
    r.tick = tick;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_typed(input logic [3:0] key, input logic tick, input display_t w);
    row_t r;
    r = '{default: '0};
    r.key = key;
    r.tick = tick;
    r.typed = 1'b1;
    r.want = w;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [2:0] addr, input logic [31:0] value);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.addr = addr;
    r.value = value;
    dir_rows.push_back(r);
  endfunction

  // one apb transfer: setup, access, then back to idle
  task automatic apb_cycle(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                           output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // register write once the block has drained, then read back the step register
  task automatic config_write(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] rd;
    s_tvalid <= 1'b0;
    while (display_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    apb_cycle(1'b1, addr, value, rd);
    if (addr == REG_TICKS_ADDR) sw_ticks = value[7:0];
    cfg_writes++;
    apb_cycle(1'b0, REG_TICKS_ADDR, 32'd0, rd);
    if (rd[7:0] !== sw_ticks) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register read back: expected %0d got %0d", sw_ticks, rd[7:0]);
    end
  endtask

  // send one item and record what it should show
  task automatic send_item(input logic [3:0] key, input logic tick, input bit typed,
                           input display_t want);
    int n;
    display_t p;
    n = idle_len();
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, tick, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p = stopwatch_advance(key, tick);
    display_due.push_back(typed ? want : p);
    items_sent++;
  endtask

  // result receiver stalls
  initial begin
    int n;
    wait (rst === 1'b0);
    forever begin
      n = idle_len();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin
    display_t got;
    display_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = display_t'(m_tdata);
      results_seen++;
      if (display_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result item with nothing expected: %h", m_tdata);
      end else begin
        want = display_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("item %0d: expected digits %h%h%h%h dn %b led %h mode %0d pad %h, got %h%h%h%h dn %b led %h mode %0d pad %h",
                     results_seen, want.thousands, want.hundreds, want.tens, want.ones,
                     want.down, want.leds, want.mode, want.pad, got.thousands,
                     got.hundreds, got.tens, got.ones, got.down, got.leds, got.mode,
                     got.pad);
        end
      end
    end
  end

  // stimulus
  initial begin
    display_t none;
    logic [3:0] key;
    logic [3:0] held;
    logic [7:0] t;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    calm = 1'b0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    cfg_writes = 0;
    none = '0;
    held = 4'd0;
    stopwatch_reset();

    // directed table
    add_typed(4'd0, 1'b0, mk_display(DIGIT_BLANK, DIGIT_BLANK, DIGIT_BLANK, DIGIT_BLANK,
                                     1'b1, LED_RUN, MODE_CODE_RUN));
    add_typed(KEY_CLEAR, 1'b0, mk_display(DIGIT_BLANK, DIGIT_BLANK, DIGIT_BLANK, DIGIT_BLANK,
                                          1'b1, LED_RUN, MODE_CODE_CLEAR));
    add_typed(4'd0, 1'b0, mk_display(DIGIT_MAX, DIGIT_MAX, DIGIT_MAX, DIGIT_MAX,
                                     1'b1, LED_RUN, MODE_CODE_RUN));
    // reset step count of five: fifth tick wraps 0000 down to 9999
    for (int i = 0; i < 5; i++) add_item(4'd0, 1'b1);
    // zero step register, upper write bits ignored
    add_cfg(REG_TICKS_ADDR, 32'hFFFF_FF00);
    add_item(4'd0, 1'b1);
    add_item(KEY_DIR, 1'b1);
    add_item(KEY_DIR, 1'b1);
    // pause drops ticks, clear while paused and counting up
    add_item(KEY_RUN_PAUSE, 1'b1);
    add_item(4'd0, 1'b1);
    add_item(KEY_CLEAR, 1'b0);
    add_item(4'd0, 1'b0);
    // key codes above nine are no edge
    add_item(4'd15, 1'b1);
    add_item(KEY_RUN_PAUSE, 1'b0);
    add_item(4'd10, 1'b1);
    add_item(4'd4, 1'b1);
    // write beyond the register list is ignored
    add_cfg(REG_BEYOND_ADDR, 32'h0000_0001);
    add_item(4'd0, 1'b1);
    // largest step count, then lowered below the running prescale count
    add_cfg(REG_TICKS_ADDR, 32'd255);
    for (int i = 0; i < 6; i++) add_item(4'd9, 1'b1);
    add_cfg(REG_TICKS_ADDR, 32'd2);
    add_item(4'd0, 1'b1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) config_write(dir_rows[i].addr, dir_rows[i].value);
      else send_item(dir_rows[i].key, dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
    end

    // random phases, each under its own step setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = (ph % 4 == 2);
      if ($urandom_range(0, 3) == 0) config_write(REG_BEYOND_ADDR, $urandom());
      case (ph)
        0: t = 8'd1;
        1: t = 8'd255;
        2: t = 8'd0;
        default: t = ($urandom_range(0, 5) == 0) ? 8'($urandom()) : 8'($urandom_range(1, 6));
      endcase
      config_write(REG_TICKS_ADDR, ($urandom() & 32'hFFFF_FF00) | {24'd0, t});
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // key presses held for a while, mostly the active keys
        if ($urandom_range(0, 9) < 4) key = held;
        else begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: key = 4'd0;
            10, 11, 12, 13, 14, 15: key = 4'($urandom_range(1, 3));
            16, 17, 18: key = 4'($urandom_range(4, 9));
            default: key = 4'($urandom_range(10, 15));
          endcase
        end
        held = key;
        send_item(key, ($urandom_range(0, 9) < 6), 1'b0, none);
      end
    end

    // drain
    s_tvalid <= 1'b0;
    while (display_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d items and %0d results over %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("step settings included 0, 1, 2, 255 and random values; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
